>>> src/keyboard_scancode_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Keyboard scan-code decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_DECODER_UNIT_ASSERT_SVH
`define KEYBOARD_SCANCODE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define KSD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("keyboard decoder check failed");

// next-cycle implication, ignored while in reset
`define KSD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("keyboard decoder check failed");

`endif

>>> src/ksd_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard scan-code decoder package
// Result kinds, actions, scan codes, key tables and shared structs.
// ----------------------------------------------------------------------------
package ksd_pkg;

    typedef enum logic [2:0] {
        KIND_NONE        = 3'd0,
        KIND_CHAR        = 3'd1,
        KIND_TAB         = 3'd2,
        KIND_BREAK       = 3'd3,
        KIND_NEW_CONSOLE = 3'd4,
        KIND_F11         = 3'd5,
        KIND_F12         = 3'd6,
        KIND_CMD         = 3'd7
    } ksd_kind_t;

    typedef enum logic [1:0] {
        ACT_SCAN  = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_START = 2'd2
    } ksd_action_t;

    localparam logic [7:0] SC_TAB      = 8'h0F;
    localparam logic [7:0] SC_LSHIFT   = 8'h2A;
    localparam logic [7:0] SC_RSHIFT   = 8'h36;
    localparam logic [7:0] SC_LSHIFT_R = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_R = 8'hB6;
    localparam logic [7:0] SC_CAPS     = 8'h3A;
    localparam logic [7:0] SC_NUM      = 8'h45;
    localparam logic [7:0] SC_SCROLL   = 8'h46;
    localparam logic [7:0] SC_F1       = 8'h3B;
    localparam logic [7:0] SC_F2       = 8'h3C;
    localparam logic [7:0] SC_F11      = 8'h57;
    localparam logic [7:0] SC_F12      = 8'h58;
    localparam logic [7:0] SC_ACK      = 8'hFA;
    localparam logic [7:0] SC_RESEND   = 8'hFE;

    localparam logic [7:0] CMD_LED     = 8'hED;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_Z   = 8'h5A;

    // queue entry: bit3 LED byte kept, bits 2:0 LED byte
    localparam int ENTRY_W = 4;

    typedef struct packed {
        ksd_kind_t   kind;
        logic [7:0]  value;
        logic        set_left;
        logic        set_right;
        logic        clr_left;
        logic        clr_right;
        logic [2:0]  led_flip;
        logic        ack;
        logic        resend;
    } ksd_dec_t;

    typedef struct packed {
        logic        push;
        logic [2:0]  leds;
        logic        pop;
    } ksd_qreq_t;

    typedef struct packed {
        logic        not_empty;
        logic [7:0]  head_byte;
        logic        ovf_next;
    } ksd_qstat_t;

    function automatic logic [7:0] plain_char(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'h02: ch = 8'h31;  7'h03: ch = 8'h32;  7'h04: ch = 8'h33;
            7'h05: ch = 8'h34;  7'h06: ch = 8'h35;  7'h07: ch = 8'h36;
            7'h08: ch = 8'h37;  7'h09: ch = 8'h38;  7'h0A: ch = 8'h39;
            7'h0B: ch = 8'h30;  7'h0C: ch = 8'h2D;  7'h0D: ch = 8'h5E;
            7'h0E: ch = 8'h08;
            7'h10: ch = 8'h51;  7'h11: ch = 8'h57;  7'h12: ch = 8'h45;
            7'h13: ch = 8'h52;  7'h14: ch = 8'h54;  7'h15: ch = 8'h59;
            7'h16: ch = 8'h55;  7'h17: ch = 8'h49;  7'h18: ch = 8'h4F;
            7'h19: ch = 8'h50;  7'h1A: ch = 8'h40;  7'h1B: ch = 8'h5B;
            7'h1C: ch = 8'h0A;  7'h1E: ch = 8'h41;  7'h1F: ch = 8'h53;
            7'h20: ch = 8'h44;  7'h21: ch = 8'h46;  7'h22: ch = 8'h47;
            7'h23: ch = 8'h48;  7'h24: ch = 8'h4A;  7'h25: ch = 8'h4B;
            7'h26: ch = 8'h4C;  7'h27: ch = 8'h3B;  7'h28: ch = 8'h3A;
            7'h2B: ch = 8'h5D;  7'h2C: ch = 8'h5A;  7'h2D: ch = 8'h58;
            7'h2E: ch = 8'h43;  7'h2F: ch = 8'h56;
            7'h30: ch = 8'h42;  7'h31: ch = 8'h4E;  7'h32: ch = 8'h4D;
            7'h33: ch = 8'h2C;  7'h34: ch = 8'h2E;  7'h35: ch = 8'h2F;
            7'h37: ch = 8'h2A;  7'h39: ch = 8'h20;
            7'h47: ch = 8'h37;  7'h48: ch = 8'h38;  7'h49: ch = 8'h39;
            7'h4A: ch = 8'h2D;  7'h4B: ch = 8'h34;  7'h4C: ch = 8'h35;
            7'h4D: ch = 8'h36;  7'h4E: ch = 8'h2B;  7'h4F: ch = 8'h31;
            7'h50: ch = 8'h32;  7'h51: ch = 8'h33;  7'h52: ch = 8'h30;
            7'h53: ch = 8'h2E;
            7'h73: ch = 8'h5C;  7'h7D: ch = 8'h5C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] shifted_char(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'h02: ch = 8'h21;  7'h03: ch = 8'h22;  7'h04: ch = 8'h23;
            7'h05: ch = 8'h24;  7'h06: ch = 8'h25;  7'h07: ch = 8'h26;
            7'h08: ch = 8'h27;  7'h09: ch = 8'h28;  7'h0A: ch = 8'h29;
            7'h0B: ch = 8'h7E;  7'h0C: ch = 8'h3D;  7'h0D: ch = 8'h7E;
            7'h1A: ch = 8'h60;  7'h1B: ch = 8'h7B;
            7'h27: ch = 8'h2B;  7'h28: ch = 8'h2A;  7'h2B: ch = 8'h7D;
            7'h33: ch = 8'h3C;  7'h34: ch = 8'h3E;  7'h35: ch = 8'h3F;
            7'h73: ch = 8'h5F;  7'h7D: ch = 8'h7C;
            default: ch = plain_char(idx);
        endcase
        return ch;
    endfunction

endpackage

>>> src/ksd_decode.sv
// ----------------------------------------------------------------------------
// Keyboard scan-code decode
// Maps one scan byte to a character or event and flags its key actions.
// ----------------------------------------------------------------------------
module ksd_decode (
    input  logic [7:0]        code,
    input  logic              shift_active,
    input  logic              caps,
    output ksd_pkg::ksd_dec_t dec
);

    logic [7:0] ch;
    logic [7:0] ch_case;

    always_comb begin
        if (code[7]) begin
            ch = 8'h00;
        end else if (shift_active) begin
            ch = ksd_pkg::shifted_char(code[6:0]);
        end else begin
            ch = ksd_pkg::plain_char(code[6:0]);
        end
    end

    always_comb begin
        ch_case = ch;
        if (ch >= ksd_pkg::CHAR_UC_A && ch <= ksd_pkg::CHAR_UC_Z && caps == shift_active) begin
            ch_case = ch + ksd_pkg::CASE_OFFSET;
        end
    end

    always_comb begin
        dec           = '0;
        dec.value     = ch_case;
        dec.kind      = (ch_case != 8'h00) ? ksd_pkg::KIND_CHAR : ksd_pkg::KIND_NONE;
        case (code)
            ksd_pkg::SC_TAB:      dec.kind = ksd_pkg::KIND_TAB;
            ksd_pkg::SC_LSHIFT:   dec.set_left = 1'b1;
            ksd_pkg::SC_RSHIFT:   dec.set_right = 1'b1;
            ksd_pkg::SC_LSHIFT_R: dec.clr_left = 1'b1;
            ksd_pkg::SC_RSHIFT_R: dec.clr_right = 1'b1;
            ksd_pkg::SC_CAPS:     dec.led_flip = 3'b100;
            ksd_pkg::SC_NUM:      dec.led_flip = 3'b010;
            ksd_pkg::SC_SCROLL:   dec.led_flip = 3'b001;
            ksd_pkg::SC_F1: begin
                if (shift_active) begin
                    dec.kind = ksd_pkg::KIND_BREAK;
                end
            end
            ksd_pkg::SC_F2: begin
                if (shift_active) begin
                    dec.kind = ksd_pkg::KIND_NEW_CONSOLE;
                end
            end
            ksd_pkg::SC_F11:      dec.kind = ksd_pkg::KIND_F11;
            ksd_pkg::SC_F12:      dec.kind = ksd_pkg::KIND_F12;
            ksd_pkg::SC_ACK:      dec.ack = 1'b1;
            ksd_pkg::SC_RESEND:   dec.resend = 1'b1;
            default: ;
        endcase
    end

endmodule

>>> src/ksd_cmd_queue.sv
// ----------------------------------------------------------------------------
// Keyboard command queue
// Byte queue for keyboard commands, held as LED command pairs in a memory
// with the head entry prefetched into a read register.
// ----------------------------------------------------------------------------
module ksd_cmd_queue #(
    parameter int DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ksd_pkg::ksd_qreq_t  req,
    output ksd_pkg::ksd_qstat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ALMOST = CNT_W'(DEPTH - 1);

    logic [ksd_pkg::ENTRY_W-1:0] mem_reg [DEPTH];
    logic [ksd_pkg::ENTRY_W-1:0] rd_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             half_reg, half_next;
    logic             ovf_reg, ovf_next;

    logic                        wr_en;
    logic [ksd_pkg::ENTRY_W-1:0] wr_data;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        half_next  = half_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        wr_data    = {1'b1, req.leds};
        if (req.push) begin
            if (count_reg == CNT_FULL) begin
                ovf_next = 1'b1;
            end else begin
                wr_en     = 1'b1;
                tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
                if (count_reg == CNT_ALMOST) begin
                    // only the command byte fits
                    wr_data    = {1'b0, req.leds};
                    count_next = count_reg + CNT_W'(1);
                    ovf_next   = 1'b1;
                end else begin
                    count_next = count_reg + CNT_W'(2);
                end
            end
        end else if (req.pop && count_reg != '0) begin
            count_next = count_reg - CNT_W'(1);
            if (!half_reg && rd_reg[ksd_pkg::ENTRY_W-1]) begin
                half_next = 1'b1;
            end else begin
                half_next = 1'b0;
                head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            half_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            half_reg  <= half_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[tail_reg] <= wr_data;
        end
        if (wr_en && tail_reg == head_next) begin
            rd_reg <= wr_data;
        end else begin
            rd_reg <= mem_reg[head_next];
        end
    end

    always_comb begin
        stat.not_empty = (count_reg != '0);
        stat.head_byte = half_reg ? {5'b00000, rd_reg[2:0]} : ksd_pkg::CMD_LED;
        stat.ovf_next  = ovf_next;
    end

endmodule

>>> src/keyboard_scancode_decoder_unit.sv
// ----------------------------------------------------------------------------
// Keyboard scan-code decoder unit
// Set 1 scan codes to characters and events for a Japanese layout, with
// shift and lock-key tracking and a queue of LED commands for the keyboard.
// ----------------------------------------------------------------------------
// Takes one item per clock unless m_tready holds a waiting result, and returns
// exactly one result item for each: the item is registered, decoded and
// acted on in one pass, and the result is registered. Throughput is one item
// per cycle without back-pressure, set by the single pass from input register
// to result register; the command queue memory keeps its head entry in a read
// register so that a send never waits on a memory read. The result register
// and the input register are separate, so one item is still taken while a
// result waits on m_tready.
module keyboard_scancode_decoder_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,   // initial_leds
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] scan_code
    input  logic [1:0]  s_tuser,       // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [7:0] value, [8] queue_overflow
    output logic [2:0]  m_tuser        // [2:0] kind
);

    logic       in_valid_reg;
    logic [1:0] in_action_reg;
    logic [7:0] in_code_reg;

    logic       out_valid_reg;
    logic [2:0] out_kind_reg, out_kind_next;
    logic [7:0] out_value_reg, out_value_next;
    logic       out_ovf_reg;

    logic [2:0] init_leds_reg;
    logic [1:0] shift_reg, shift_next;
    logic [2:0] leds_reg, leds_next;
    logic       ack_reg, ack_next;
    logic [7:0] sent_reg, sent_next;

    logic advance;
    logic fire;

    ksd_pkg::ksd_dec_t   dec;
    ksd_pkg::ksd_qreq_t  qreq;
    ksd_pkg::ksd_qstat_t qstat;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    ksd_decode u_decode (
        .code         (in_code_reg),
        .shift_active (shift_reg != 2'b00),
        .caps         (leds_reg[2]),
        .dec          (dec)
    );

    ksd_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (qreq),
        .stat    (qstat)
    );

    always_comb begin
        shift_next     = shift_reg;
        leds_next      = leds_reg;
        ack_next       = ack_reg;
        sent_next      = sent_reg;
        out_kind_next  = ksd_pkg::KIND_NONE;
        out_value_next = 8'h00;
        qreq           = '0;
        if (fire) begin
            case (ksd_pkg::ksd_action_t'(in_action_reg))
                ksd_pkg::ACT_SCAN: begin
                    out_kind_next  = dec.kind;
                    out_value_next = dec.value;
                    if (dec.set_left) begin
                        shift_next[0] = 1'b1;
                    end
                    if (dec.set_right) begin
                        shift_next[1] = 1'b1;
                    end
                    if (dec.clr_left) begin
                        shift_next[0] = 1'b0;
                    end
                    if (dec.clr_right) begin
                        shift_next[1] = 1'b0;
                    end
                    leds_next = leds_reg ^ dec.led_flip;
                    qreq.push = (dec.led_flip != 3'b000);
                    qreq.leds = leds_next;
                    if (dec.ack) begin
                        ack_next = 1'b0;
                    end
                    if (dec.resend && ack_reg) begin
                        out_kind_next  = ksd_pkg::KIND_CMD;
                        out_value_next = sent_reg;
                    end
                end
                ksd_pkg::ACT_SEND: begin
                    if (qstat.not_empty && !ack_reg) begin
                        qreq.pop       = 1'b1;
                        sent_next      = qstat.head_byte;
                        ack_next       = 1'b1;
                        out_kind_next  = ksd_pkg::KIND_CMD;
                        out_value_next = qstat.head_byte;
                    end
                end
                ksd_pkg::ACT_START: begin
                    leds_next = init_leds_reg;
                    qreq.push = 1'b1;
                    qreq.leds = init_leds_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            init_leds_reg <= 3'b000;
            shift_reg     <= 2'b00;
            leds_reg      <= 3'b000;
            ack_reg       <= 1'b0;
            sent_reg      <= 8'h00;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en) begin
                init_leds_reg <= cfg_wr_data;
            end
            shift_reg <= shift_next;
            leds_reg  <= leds_next;
            ack_reg   <= ack_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_code_reg   <= s_tdata;
        end
        if (fire) begin
            out_kind_reg  <= out_kind_next;
            out_value_reg <= out_value_next;
            out_ovf_reg   <= qstat.ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_ovf_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;

endmodule

>>> src/ksd_checker.sv
// ----------------------------------------------------------------------------
// Keyboard scan-code decoder checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyboard_scancode_decoder_unit_assert.svh"

module ksd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    logic        ovf_seen_reg;
    logic [18:0] m_word;
    logic        plain_kind;

    assign m_word     = {m_tuser, m_tdata};
    assign plain_kind = (m_tuser != ksd_pkg::KIND_CHAR) && (m_tuser != ksd_pkg::KIND_CMD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[8]) begin
            ovf_seen_reg <= 1'b1;
        end
    end

    `KSD_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_word))
    `KSD_ASSERT_IMP(a_ovf_sticky, aclk, aresetn, m_tvalid && ovf_seen_reg, m_tdata[8])
    `KSD_ASSERT_IMP(a_value_zero, aclk, aresetn, m_tvalid && plain_kind, m_tdata[7:0] == 8'h00)
    `KSD_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[15:9] == 7'b0000000)

endmodule

bind keyboard_scancode_decoder_unit ksd_checker u_ksd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
